### rtl/mouse_motion_accel_skew_unit_assert.svh
// Assertion macros for the checker module of the motion unit.
// Needs aclk and aresetn in the scope that uses the macros.
`ifndef MOUSE_MOTION_ACCEL_SKEW_UNIT_ASSERT_SVH
`define MOUSE_MOTION_ACCEL_SKEW_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define MMAS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define MMAS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/mmas_pkg.sv
// Shared widths, codes, command/status structs and saturation helpers
// for the motion unit. No dependencies.
package mmas_pkg;

    localparam int DATA_W              = 16;
    localparam int CNT_W               = 17;
    localparam int CFG_IDX_W           = 4;
    localparam int DVD_W               = 32;
    localparam int MUL_W               = DATA_W + 1;
    localparam int ACC_W               = 2 * MUL_W;
    localparam int COEF_FRAC_BITS_DEF  = 14;

    // 1.0 in Q2.14, reset value of both cosine coefficients
    localparam logic signed [DATA_W-1:0] COEF_RESET = DATA_W'(16384);

    localparam logic signed [DATA_W-1:0] VAL_MAX = DATA_W'(2 ** (DATA_W - 1) - 1);
    localparam logic signed [DATA_W-1:0] VAL_MIN = ~VAL_MAX;
    localparam logic signed [ACC_W-1:0]  SAT_HI  = ACC_W'(2 ** (DATA_W - 1) - 1);
    localparam logic signed [ACC_W-1:0]  SAT_LO  = ~SAT_HI;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SKIP_COUNT  = 4'd0,
        REG_ACCEL_DIV_X = 4'd1,
        REG_ACCEL_DIV_Y = 4'd2,
        REG_SKEW_ENABLE = 4'd3,
        REG_COS_X       = 4'd4,
        REG_SIN_X       = 4'd5,
        REG_COS_Y       = 4'd6,
        REG_SIN_Y       = 4'd7
    } cfg_reg_t;

    typedef enum logic [2:0] {
        MUL_MAGX = 3'd0,
        MUL_MAGY = 3'd1,
        MUL_XCX  = 3'd2,
        MUL_YSX  = 3'd3,
        MUL_YCY  = 3'd4,
        MUL_XSY  = 3'd5
    } mul_sel_t;

    typedef enum logic [2:0] {
        ACC_NONE   = 3'd0,
        ACC_X_LOAD = 3'd1,
        ACC_X_SUB  = 3'd2,
        ACC_Y_LOAD = 3'd3,
        ACC_Y_ADD  = 3'd4
    } acc_op_t;

    typedef struct packed {
        logic     load_in;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     div_start_x;
        logic     div_start_y;
        logic     accel_upd;
        acc_op_t  acc_op;
        logic     skew_upd;
        logic     cnt_upd;
        logic     out_load;
    } mmas_cmd_t;

    typedef struct packed {
        logic scroll_emit;
        logic accel_on;
        logic skew_on;
        logic div_busy;
    } mmas_status_t;

    function automatic logic signed [DATA_W-1:0] sat16(input logic signed [ACC_W-1:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > SAT_HI) begin
            r = VAL_MAX;
        end else if (v < SAT_LO) begin
            r = VAL_MIN;
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [DATA_W-1:0] negsat16(input logic signed [DATA_W-1:0] d);
        logic signed [DATA_W-1:0] r;
        if (d == VAL_MIN) begin
            r = VAL_MAX;
        end else begin
            r = -d;
        end
        return r;
    endfunction

endpackage

### rtl/mmas_div.sv
// Unsigned restoring divider, two quotient bits per cycle.
// Uses mmas_pkg for default widths.
module mmas_div #(
    parameter int DVD_W = mmas_pkg::DVD_W,
    parameter int DVS_W = mmas_pkg::DATA_W
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             busy,
    output logic [DVD_W-1:0] quotient
);
    import mmas_pkg::*;

    localparam int STEPS  = DVD_W / 2;
    localparam int STEP_W = $clog2(STEPS + 1);

    logic [DVD_W-1:0]  quo_reg;
    logic [DVS_W-1:0]  rem_reg;
    logic [DVS_W-1:0]  dvs_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic              busy_reg;

    logic [DVS_W:0]   cand1, cand2, dvs_ext;
    logic             ge1, ge2;
    logic [DVS_W-1:0] rem1, rem2;

    always_comb begin
        dvs_ext = {1'b0, dvs_reg};
        cand1   = {rem_reg, quo_reg[DVD_W-1]};
        ge1     = (cand1 >= dvs_ext);
        rem1    = ge1 ? DVS_W'(cand1 - dvs_ext) : cand1[DVS_W-1:0];
        cand2   = {rem1, quo_reg[DVD_W-2]};
        ge2     = (cand2 >= dvs_ext);
        rem2    = ge2 ? DVS_W'(cand2 - dvs_ext) : cand2[DVS_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= STEP_W'(STEPS);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - STEP_W'(1);
            if (cnt_reg == STEP_W'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            // dividend bits leave at the top, quotient bits enter at the bottom
            quo_reg <= {quo_reg[DVD_W-3:0], ge1, ge2};
            rem_reg <= rem2;
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

### rtl/mmas_dp.sv
// Datapath: config registers, scroll counter, shared multiplier, two dividers,
// accumulators and output register. Uses mmas_pkg and mmas_div.
module mmas_dp #(
    parameter int COEF_FRAC_BITS = mmas_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    input  logic [mmas_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mmas_pkg::DATA_W-1:0]         cfg_data,
    input  logic signed [mmas_pkg::DATA_W-1:0]  s_delta_x,
    input  logic signed [mmas_pkg::DATA_W-1:0]  s_delta_y,
    input  logic                                s_scroll_active,
    input  mmas_pkg::mmas_cmd_t                 cmd,
    output mmas_pkg::mmas_status_t              status,
    output logic                                out_kind,
    output logic signed [mmas_pkg::DATA_W-1:0]  out_first,
    output logic signed [mmas_pkg::DATA_W-1:0]  out_second
);
    import mmas_pkg::*;

    localparam logic signed [ACC_W-1:0] QD_BIAS  = ACC_W'((2 ** COEF_FRAC_BITS) - 1);
    localparam logic [CNT_W-1:0]        CNT_FULL = '1;

    logic [DATA_W-1:0]        skip_reg, div_x_reg, div_y_reg;
    logic                     skew_en_reg;
    logic signed [DATA_W-1:0] cos_x_reg, sin_x_reg, cos_y_reg, sin_y_reg;
    logic [CNT_W-1:0]         count_reg;

    logic signed [DATA_W-1:0] x_reg, y_reg;
    logic                     kind_reg;
    logic signed [ACC_W-1:0]  prod_reg, acc_x_reg, acc_y_reg;
    logic                     okind_reg;
    logic signed [DATA_W-1:0] ofirst_reg, osecond_reg;

    logic [DATA_W-1:0]        mag_x, mag_y;
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic                     busy_x, busy_y;
    logic [DVD_W-1:0]         quo_x, quo_y;

    function automatic logic signed [DATA_W-1:0] accel_sat(
        input logic signed [DATA_W-1:0] d,
        input logic [DATA_W-1:0]        mag,
        input logic [DVD_W-1:0]         q
    );
        logic [ACC_W-1:0]        sum;
        logic signed [ACC_W-1:0] v;
        sum = {{(ACC_W - DATA_W){1'b0}}, mag} + {{(ACC_W - DVD_W){1'b0}}, q};
        v   = d[DATA_W-1] ? -$signed(sum) : $signed(sum);
        return sat16(v);
    endfunction

    // truncate toward zero: bias negative values before the arithmetic shift
    function automatic logic signed [DATA_W-1:0] qdiv(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] t;
        t = v[ACC_W-1] ? ((v + QD_BIAS) >>> COEF_FRAC_BITS) : (v >>> COEF_FRAC_BITS);
        return sat16(t);
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skip_reg    <= '0;
            div_x_reg   <= '0;
            div_y_reg   <= '0;
            skew_en_reg <= 1'b0;
            cos_x_reg   <= COEF_RESET;
            sin_x_reg   <= '0;
            cos_y_reg   <= COEF_RESET;
            sin_y_reg   <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_SKIP_COUNT:  skip_reg    <= cfg_data;
                REG_ACCEL_DIV_X: div_x_reg   <= cfg_data;
                REG_ACCEL_DIV_Y: div_y_reg   <= cfg_data;
                REG_SKEW_ENABLE: skew_en_reg <= cfg_data[0];
                REG_COS_X:       cos_x_reg   <= cfg_data;
                REG_SIN_X:       sin_x_reg   <= cfg_data;
                REG_COS_Y:       cos_y_reg   <= cfg_data;
                REG_SIN_Y:       sin_y_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.cnt_upd) begin
            // an emitted report clears the count, then it advances as usual
            if (status.scroll_emit) begin
                count_reg <= CNT_W'(1);
            end else if (count_reg != CNT_FULL) begin
                count_reg <= count_reg + CNT_W'(1);
            end
        end
    end

    always_comb begin
        mag_x = x_reg[DATA_W-1] ? DATA_W'(-x_reg) : x_reg;
        mag_y = y_reg[DATA_W-1] ? DATA_W'(-y_reg) : y_reg;
        case (cmd.mul_sel)
            MUL_MAGX: begin mul_a = {1'b0, mag_x};         mul_b = {1'b0, mag_x};             end
            MUL_MAGY: begin mul_a = {1'b0, mag_y};         mul_b = {1'b0, mag_y};             end
            MUL_XCX:  begin mul_a = {x_reg[DATA_W-1], x_reg}; mul_b = {cos_x_reg[DATA_W-1], cos_x_reg}; end
            MUL_YSX:  begin mul_a = {y_reg[DATA_W-1], y_reg}; mul_b = {sin_x_reg[DATA_W-1], sin_x_reg}; end
            MUL_YCY:  begin mul_a = {y_reg[DATA_W-1], y_reg}; mul_b = {cos_y_reg[DATA_W-1], cos_y_reg}; end
            MUL_XSY:  begin mul_a = {x_reg[DATA_W-1], x_reg}; mul_b = {sin_y_reg[DATA_W-1], sin_y_reg}; end
            default:  begin mul_a = '0;                    mul_b = '0;                        end
        endcase
    end

    mmas_div #(
        .DVD_W (DVD_W),
        .DVS_W (DATA_W)
    ) u_div_x (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start_x),
        .dividend (prod_reg[DVD_W-1:0]),
        .divisor  (div_x_reg),
        .busy     (busy_x),
        .quotient (quo_x)
    );

    mmas_div #(
        .DVD_W (DVD_W),
        .DVS_W (DATA_W)
    ) u_div_y (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start_y),
        .dividend (prod_reg[DVD_W-1:0]),
        .divisor  (div_y_reg),
        .busy     (busy_y),
        .quotient (quo_y)
    );

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            x_reg    <= s_delta_x;
            y_reg    <= s_delta_y;
            kind_reg <= s_scroll_active;
        end else if (cmd.accel_upd) begin
            x_reg <= accel_sat(x_reg, mag_x, quo_x);
            y_reg <= accel_sat(y_reg, mag_y, quo_y);
        end else if (cmd.skew_upd) begin
            x_reg <= qdiv(acc_x_reg);
            y_reg <= qdiv(acc_y_reg);
        end

        if (cmd.mul_en) begin
            prod_reg <= mul_a * mul_b;
        end

        case (cmd.acc_op)
            ACC_X_LOAD: acc_x_reg <= prod_reg;
            ACC_X_SUB:  acc_x_reg <= acc_x_reg - prod_reg;
            ACC_Y_LOAD: acc_y_reg <= prod_reg;
            ACC_Y_ADD:  acc_y_reg <= acc_y_reg + prod_reg;
            default: ;
        endcase

        if (cmd.out_load) begin
            okind_reg   <= kind_reg;
            ofirst_reg  <= kind_reg ? negsat16(y_reg) : x_reg;
            osecond_reg <= kind_reg ? x_reg : negsat16(y_reg);
        end
    end

    assign status.scroll_emit = (count_reg >= {1'b0, skip_reg});
    assign status.accel_on    = (|div_x_reg) && (|div_y_reg);
    assign status.skew_on     = skew_en_reg;
    assign status.div_busy    = busy_x || busy_y;

    assign out_kind   = okind_reg;
    assign out_first  = ofirst_reg;
    assign out_second = osecond_reg;

endmodule

### rtl/mmas_ctrl.sv
// Controller state machine: sequences multiplier, dividers and accumulators,
// owns the input ready and output valid. Uses mmas_pkg.
module mmas_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    input  logic                   s_scroll_active,
    input  logic                   m_ready,
    input  mmas_pkg::mmas_status_t status,
    output logic                   s_ready,
    output logic                   m_valid,
    output mmas_pkg::mmas_cmd_t    cmd
);
    import mmas_pkg::*;

    typedef enum logic [13:0] {
        ST_IDLE = 14'h0001,
        ST_SCR  = 14'h0002,
        ST_MX   = 14'h0004,
        ST_MY   = 14'h0008,
        ST_DS   = 14'h0010,
        ST_DIV  = 14'h0020,
        ST_ACC  = 14'h0040,
        ST_K0   = 14'h0080,
        ST_K1   = 14'h0100,
        ST_K2   = 14'h0200,
        ST_K3   = 14'h0400,
        ST_K4   = 14'h0800,
        ST_QD   = 14'h1000,
        ST_DONE = 14'h2000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    if (s_scroll_active) begin
                        state_next = ST_SCR;
                    end else if (status.accel_on) begin
                        state_next = ST_MX;
                    end else if (status.skew_on) begin
                        state_next = ST_K0;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SCR: begin
                cmd.cnt_upd = 1'b1;
                state_next  = status.scroll_emit ? ST_DONE : ST_IDLE;
            end
            ST_MX: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_MAGX;
                state_next  = ST_MY;
            end
            ST_MY: begin
                cmd.mul_en      = 1'b1;
                cmd.mul_sel     = MUL_MAGY;
                cmd.div_start_x = 1'b1;
                state_next      = ST_DS;
            end
            ST_DS: begin
                cmd.div_start_y = 1'b1;
                state_next      = ST_DIV;
            end
            ST_DIV: begin
                if (!status.div_busy) begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC: begin
                cmd.accel_upd = 1'b1;
                state_next    = status.skew_on ? ST_K0 : ST_DONE;
            end
            ST_K0: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_XCX;
                state_next  = ST_K1;
            end
            ST_K1: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_YSX;
                cmd.acc_op  = ACC_X_LOAD;
                state_next  = ST_K2;
            end
            ST_K2: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_YCY;
                cmd.acc_op  = ACC_X_SUB;
                state_next  = ST_K3;
            end
            ST_K3: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_XSY;
                cmd.acc_op  = ACC_Y_LOAD;
                state_next  = ST_K4;
            end
            ST_K4: begin
                cmd.acc_op = ACC_Y_ADD;
                state_next = ST_QD;
            end
            ST_QD: begin
                cmd.skew_upd = 1'b1;
                state_next   = ST_DONE;
            end
            ST_DONE: begin
                // hold until the output register is free or being drained
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule

### rtl/mouse_motion_accel_skew_unit.sv
// Top level of the motion unit: controller plus datapath.
// Uses mmas_pkg, mmas_ctrl, mmas_dp.
//
// Turns one sensor motion request (dx, dy, scroll level) into at most one
// report. A scroll request passes the counter update and, if it yields a report,
// the done state, which waits for a free output register; the first report comes
// on request skip setting plus one, and after it one in every skip setting (at
// least every request). A move request runs, if acceleration is on, the squares on
// the single shared 17x17 multiplier and the two-bits-per-cycle dividers (each fed
// a 32-bit square), then, if skew is on, the rotation and rescale, then the done
// state. One request is in work at a time; a finished report waits in the output
// register while the next request is taken. Configuration writes are always ready
// and must only be issued while the unit is idle.
module mouse_motion_accel_skew_unit #(
    parameter int COEF_FRAC_BITS = mmas_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [mmas_pkg::DATA_W-1:0] s_delta_x,
    input  logic signed [mmas_pkg::DATA_W-1:0] s_delta_y,
    input  logic                               s_scroll_active,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_report_kind,
    output logic signed [mmas_pkg::DATA_W-1:0] m_first_value,
    output logic signed [mmas_pkg::DATA_W-1:0] m_second_value,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [mmas_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mmas_pkg::DATA_W-1:0]        cfg_data
);
    import mmas_pkg::*;

    mmas_cmd_t    cmd;
    mmas_status_t status;

    assign cfg_ready = 1'b1;

    mmas_ctrl u_ctrl (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_scroll_active (s_scroll_active),
        .m_ready         (m_ready),
        .status          (status),
        .s_ready         (s_ready),
        .m_valid         (m_valid),
        .cmd             (cmd)
    );

    mmas_dp #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid && cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_delta_x       (s_delta_x),
        .s_delta_y       (s_delta_y),
        .s_scroll_active (s_scroll_active),
        .cmd             (cmd),
        .status          (status),
        .out_kind        (m_report_kind),
        .out_first       (m_first_value),
        .out_second      (m_second_value)
    );

endmodule

### rtl/mmas_chk.sv
// Port-level checker for the motion unit and its bind to the top level.
// Uses mmas_pkg and the assertion macro header.
`include "mouse_motion_accel_skew_unit_assert.svh"

module mmas_chk (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_valid,
    input logic                               s_ready,
    input logic                               m_valid,
    input logic                               m_ready,
    input logic                               m_report_kind,
    input logic signed [mmas_pkg::DATA_W-1:0] m_first_value,
    input logic signed [mmas_pkg::DATA_W-1:0] m_second_value
);
    import mmas_pkg::*;

    // a stalled report keeps its contents
    `MMAS_ASSERT_NXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_report_kind) && $stable(m_first_value) && $stable(m_second_value), "stalled report changed")

    // one request at a time: the unit is busy right after an accept
    `MMAS_ASSERT_NXT(a_busy_after_accept, s_valid && s_ready, !s_ready, "request accepted while busy")

    // no report can appear in the cycle right after an accept
    `MMAS_ASSERT_NXT(a_no_instant_report, s_valid && s_ready, !$rose(m_valid), "report appeared too early")

    // a new report is loaded only on the way back to idle
    `MMAS_ASSERT_NOW(a_idle_on_report, $rose(m_valid), s_ready, "report loaded while busy")

endmodule

bind mouse_motion_accel_skew_unit mmas_chk u_mmas_chk (.*);
